>>> rtl/core/qse_pkg.sv
// Shared types for the quicksort engine core: element values, the link that
// runs between neighboring sort cells, and the per-cycle cell control.
// No dependencies.
package qse_pkg;

    typedef logic signed [31:0] t_value;

    // What a cell shows its neighbors: occupancy, whether its held value is
    // greater than the value being inserted, and the held value itself.
    typedef struct packed {
        logic   valid;
        logic   gt;
        t_value value;
    } t_link;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_ctrl;

endpackage

>>> rtl/core/quicksort_engine_core.sv
// Top level of the quicksort engine core: a row of sort cells that keeps the
// loaded set in ascending order, plus load and unload control.
// Depends on qse_pkg and qse_cell.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | i_value, i_last_in                      | start high, busy low
//  result  | o_sorted_value, o_last_out, o_truncated | o_strobe, one cycle each
//
// On each element transfer every cell compares against the new
// value in parallel and the greater values move one cell up.
// After the closing element the set unloads from cell zero, one result per
// cycle; busy is high exactly while the results leave.
// Reset empties the row and the count.
// The receiver cannot stall; results leave on consecutive cycles.
module quicksort_engine_core #(
    parameter int DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  qse_pkg::t_value i_value,
    input  logic            i_last_in,
    output logic            o_strobe,
    output qse_pkg::t_value o_sorted_value,
    output logic            o_last_out,
    output logic            o_truncated
);
    import qse_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_LOAD,
        ST_UNLOAD
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          w_accept;
    logic          w_full;
    t_ctrl         w_ctrl;
    t_link         w_link [DEPTH];

    assign w_accept = start && (r_state == ST_LOAD);
    assign w_full   = (r_count == CW'(DEPTH));

    assign w_ctrl.insert = w_accept && !w_full;
    assign w_ctrl.shift  = (r_state == ST_UNLOAD);

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_link w_left;
        t_link w_right;
        if (k == 0) begin : g_first
            assign w_left = '{valid: 1'b1, gt: 1'b0, value: i_value};
        end else begin : g_mid_left
            assign w_left = w_link[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = '{valid: 1'b0, gt: 1'b0, value: i_value};
        end else begin : g_mid_right
            assign w_right = w_link[k+1];
        end
        qse_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_x     (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_in) begin
                            r_count <= '0;
                            r_state <= ST_UNLOAD;
                        end else if (!w_full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                ST_UNLOAD: begin
                    // The element leaving now is the final one once the next
                    // cell up is empty.
                    if (!w_link[1].valid) begin
                        r_ovf   <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy           = (r_state == ST_UNLOAD);
    assign o_strobe       = (r_state == ST_UNLOAD);
    assign o_sorted_value = w_link[0].value;
    assign o_last_out     = !w_link[1].valid;
    assign o_truncated    = r_ovf;

    a_close_unloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_in) |=> o_strobe)
        else $error("closing transfer did not start the unload");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_out) |=> !busy)
        else $error("busy still high after the final result");

    a_unload_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> w_link[0].valid)
        else $error("result strobed from an empty cell");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && !i_last_in) |=> (w_full && r_ovf))
        else $error("transfer into a full row was not dropped and flagged");

endmodule

>>> rtl/core/qse_cell.sv
// One sort cell: holds one element and its valid bit, inserts by shifting
// toward higher indexes and unloads by shifting toward index zero.
// Depends on qse_pkg.
module qse_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qse_pkg::t_ctrl i_ctrl,
    input  qse_pkg::t_value i_x,
    input  qse_pkg::t_link i_left,
    input  qse_pkg::t_link i_right,
    output qse_pkg::t_link o_link
);
    import qse_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_value r_value;
    t_value n_value;
    logic   w_gt;

    assign w_gt = r_valid && (r_value > i_x);

    // The row is kept in ascending order with occupied cells packed from
    // index zero, so the cells that hold greater values form a suffix.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctrl.insert) begin
            if (w_gt || (!r_valid && i_left.valid)) begin
                n_valid = 1'b1;
                n_value = i_left.gt ? i_left.value : i_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule
